FILE: design/lrc_pkg.sv
// lrc_pkg: shared types and constants for the clipped line rasterizer
// no dependencies; used by lrc_walk, lrc_emit and line_rasterizer_clipped
package lrc_pkg;

  localparam int unsigned COORD_BITS_DEF  = 16;
  localparam int unsigned OFFSET_BITS_DEF = 26;

  localparam int unsigned WIDTH_W  = 13;
  localparam int unsigned HEIGHT_W = 13;
  localparam int unsigned PITCH_W  = 15;
  localparam int unsigned FMT_W    = 2;
  localparam int unsigned COLOR_W  = 32;

  // bits per pixel of the two supported formats
  localparam int unsigned BPP_WIDE   = 32;
  localparam int unsigned BPP_NARROW = 24;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);
  localparam logic [PITCH_W-1:0]  PITCH_RST  = PITCH_W'(2560);

  typedef enum logic [FMT_W-1:0] {
    FMT_WIDE   = 2'd0,
    FMT_NARROW = 2'd1,
    FMT_NONE   = 2'd2,
    FMT_NONE_2 = 2'd3
  } pix_fmt_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_PITCH  = 2'd2,
    REG_FORMAT = 2'd3
  } reg_idx_e;

  typedef enum logic [0:0] {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    WALK_VERT  = 2'd0,
    WALK_HORIZ = 2'd1,
    WALK_GEN   = 2'd2
  } walk_mode_e;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd3
  } dir_e;

  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [PITCH_W-1:0]  pitch;
    pix_fmt_e            fmt;
  } cfg_t;

endpackage

FILE: design/line_rasterizer_clipped.sv
// line_rasterizer_clipped: top level of the clipped line rasterizer
// depends on lrc_pkg, lrc_walk and lrc_emit
//
//   channel | dir | handshake            | contents
//   s_*     | in  | s_tvalid/s_tready    | tuser: action; tdata: endpoints, colour
//   m_*     | out | m_tvalid/m_tready    | tuser: write enable; tlast: last pixel;
//           |     |                      | tdata: x, y, byte offset, colour
//   apb     | in  | psel/penable/pready  | four 32-bit registers at 0x0..0xc
//
// one transfer per cycle in and out while m_tready is high; a step transfer's
// pixel passes the walk register, then the clip/offset result register
// the walk update (bresenham adds and compares) is combinational, so a step
// may follow every cycle; the offset multiplier sits in the second stage
// reset clears the walk (idle) and loads the default screen registers
// stalls on m_tready back up through the two stages into s_tready
module line_rasterizer_clipped
  import lrc_pkg::*;
#(
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF,
  localparam int unsigned IN_DATA_W  = ((4 * COORD_BITS + COLOR_W + 7) / 8) * 8,
  localparam int unsigned OUT_DATA_W =
    ((2 * COORD_BITS + OFFSET_BITS + COLOR_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave side
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  // tdata low to high: start_x, start_y, end_x, end_y, line_color
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  // tuser: action
  input  logic [0:0]            s_tuser_i,
  // master side
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  // tdata low to high: pixel_x, pixel_y, byte_offset, pixel_color
  output logic [OUT_DATA_W-1:0] m_tdata_o,
  // tuser: write_enable
  output logic [0:0]            m_tuser_o,
  output logic                  m_tlast_o,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t     cfg_q;
  logic     cfg_wr;
  reg_idx_e reg_idx;

  logic                         s_fire;
  logic                         walk_ready, adv;
  logic                         pix_valid, pix_last;
  logic signed [COORD_BITS-1:0] pix_x, pix_y;
  logic [COLOR_W-1:0]           pix_color;

  logic signed [COORD_BITS-1:0] out_x, out_y;
  logic                         out_we, out_last;
  logic [OFFSET_BITS-1:0]       out_offset;
  logic [COLOR_W-1:0]           out_color;

  // register file, word addressed
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= WIDTH_RST;
      cfg_q.height <= HEIGHT_RST;
      cfg_q.pitch  <= PITCH_RST;
      cfg_q.fmt    <= FMT_WIDE;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WIDTH:  cfg_q.width  <= pwdata[WIDTH_W-1:0];
        REG_HEIGHT: cfg_q.height <= pwdata[HEIGHT_W-1:0];
        REG_PITCH:  cfg_q.pitch  <= pwdata[PITCH_W-1:0];
        default:    cfg_q.fmt    <= pix_fmt_e'(pwdata[FMT_W-1:0]);
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = APB_DATA_W'(cfg_q.width);
      REG_HEIGHT: prdata = APB_DATA_W'(cfg_q.height);
      REG_PITCH:  prdata = APB_DATA_W'(cfg_q.pitch);
      default:    prdata = APB_DATA_W'(cfg_q.fmt);
    endcase
  end

  // input transfer
  assign s_tready_o = walk_ready;
  assign s_fire     = s_tvalid_i && s_tready_o;

  lrc_walk #(
    .COORD_BITS (COORD_BITS)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (s_fire),
    .action_i    (action_e'(s_tuser_i[0])),
    .x0_i        (s_tdata_i[COORD_BITS-1:0]),
    .y0_i        (s_tdata_i[2*COORD_BITS-1:COORD_BITS]),
    .x1_i        (s_tdata_i[3*COORD_BITS-1:2*COORD_BITS]),
    .y1_i        (s_tdata_i[4*COORD_BITS-1:3*COORD_BITS]),
    .color_i     (s_tdata_i[4*COORD_BITS+COLOR_W-1:4*COORD_BITS]),
    .adv_i       (adv),
    .ready_o     (walk_ready),
    .pix_valid_o (pix_valid),
    .pix_x_o     (pix_x),
    .pix_y_o     (pix_y),
    .pix_last_o  (pix_last),
    .pix_color_o (pix_color)
  );

  lrc_emit #(
    .COORD_BITS  (COORD_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pix_valid_i  (pix_valid),
    .pix_x_i      (pix_x),
    .pix_y_i      (pix_y),
    .pix_last_i   (pix_last),
    .pix_color_i  (pix_color),
    .adv_o        (adv),
    .out_valid_o  (m_tvalid_o),
    .out_ready_i  (m_tready_i),
    .out_x_o      (out_x),
    .out_y_o      (out_y),
    .out_we_o     (out_we),
    .out_offset_o (out_offset),
    .out_color_o  (out_color),
    .out_last_o   (out_last)
  );

  // result packing, zero padded to whole bytes
  assign m_tdata_o = OUT_DATA_W'({out_color, out_offset, out_y, out_x});
  assign m_tuser_o = out_we;
  assign m_tlast_o = out_last;

  // offset is forced to zero on pixels that are not written (clipped or unsupported format)
  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !out_we) |-> (out_offset == '0))
    else $error("clipped pixel carries a nonzero offset");

  // an unsupported format never writes
  a_fmt_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && (cfg_q.fmt == FMT_NONE || cfg_q.fmt == FMT_NONE_2)) |-> !out_we)
    else $error("write enabled under an unsupported pixel format");

  // input stalls only when both stages are full and the output is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> (pix_valid && m_tvalid_o && !m_tready_i))
    else $error("input stalled without downstream back pressure");

endmodule

FILE: design/lrc_walk.sv
// lrc_walk: line walk state (vertical, horizontal, bresenham) and the
// registered pixel stage feeding the emit stage; depends on lrc_pkg
module lrc_walk
  import lrc_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_fire_i,
  input  action_e                      action_i,
  input  logic signed [COORD_BITS-1:0] x0_i,
  input  logic signed [COORD_BITS-1:0] y0_i,
  input  logic signed [COORD_BITS-1:0] x1_i,
  input  logic signed [COORD_BITS-1:0] y1_i,
  input  logic [COLOR_W-1:0]           color_i,
  input  logic                         adv_i,
  output logic                         ready_o,
  output logic                         pix_valid_o,
  output logic signed [COORD_BITS-1:0] pix_x_o,
  output logic signed [COORD_BITS-1:0] pix_y_o,
  output logic                         pix_last_o,
  output logic [COLOR_W-1:0]           pix_color_o
);

  localparam int unsigned DIFF_W = COORD_BITS + 1;
  localparam int unsigned ERR_W  = COORD_BITS + 2;
  localparam int unsigned E2_W   = COORD_BITS + 3;

  logic                         busy_q, busy_d;
  walk_mode_e                   mode_q, mode_d;
  logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [COORD_BITS-1:0] stop_x_q, stop_x_d, stop_y_q, stop_y_d;
  logic [COORD_BITS-1:0]        dx_q, dx_d, dy_q, dy_d;
  dir_e                         dir_x_q, dir_x_d, dir_y_q, dir_y_d;
  logic signed [ERR_W-1:0]      err_q, err_d;
  logic [COLOR_W-1:0]           color_q, color_d;

  logic                         s1_valid_q, s1_valid_d;
  logic signed [COORD_BITS-1:0] s1_x_q, s1_y_q;
  logic                         s1_last_q;
  logic [COLOR_W-1:0]           s1_color_q;

  logic signed [DIFF_W-1:0]     diff_x, diff_y;
  logic [DIFF_W-1:0]            abs_x, abs_y;
  logic                         last;
  logic signed [E2_W-1:0]       e2, neg_dy, pos_dx;
  logic                         take_step;

  assign ready_o   = ~s1_valid_q | adv_i;
  assign last      = (cur_x_q == stop_x_q) && (cur_y_q == stop_y_q);
  assign take_step = in_fire_i && (action_i == ACT_STEP) && busy_q;

  assign diff_x = DIFF_W'(x1_i) - DIFF_W'(x0_i);
  assign diff_y = DIFF_W'(y1_i) - DIFF_W'(y0_i);
  assign abs_x  = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
  assign abs_y  = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);

  assign e2     = E2_W'(err_q) <<< 1;
  assign neg_dy = -E2_W'(signed'({1'b0, dy_q}));
  assign pos_dx = E2_W'(signed'({1'b0, dx_q}));

  always_comb begin
    busy_d  = busy_q;
    mode_d  = mode_q;
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    stop_x_d = stop_x_q;
    stop_y_d = stop_y_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    dir_x_d = dir_x_q;
    dir_y_d = dir_y_q;
    err_d   = err_q;
    color_d = color_q;
    if (in_fire_i && (action_i == ACT_START)) begin
      busy_d  = 1'b1;
      color_d = color_i;
      dx_d    = abs_x[COORD_BITS-1:0];
      dy_d    = abs_y[COORD_BITS-1:0];
      dir_x_d = (x1_i > x0_i) ? DIR_PLUS : ((x1_i < x0_i) ? DIR_MINUS : DIR_NONE);
      dir_y_d = (y1_i > y0_i) ? DIR_PLUS : ((y1_i < y0_i) ? DIR_MINUS : DIR_NONE);
      err_d   = ERR_W'(signed'({1'b0, abs_x[COORD_BITS-1:0]}))
              - ERR_W'(signed'({1'b0, abs_y[COORD_BITS-1:0]}));
      if (x0_i == x1_i) begin
        mode_d   = WALK_VERT;
        cur_x_d  = x0_i;
        stop_x_d = x0_i;
        cur_y_d  = (y0_i < y1_i) ? y0_i : y1_i;
        stop_y_d = (y0_i < y1_i) ? y1_i : y0_i;
      end else if (y0_i == y1_i) begin
        mode_d   = WALK_HORIZ;
        cur_y_d  = y0_i;
        stop_y_d = y0_i;
        cur_x_d  = (x0_i < x1_i) ? x0_i : x1_i;
        stop_x_d = (x0_i < x1_i) ? x1_i : x0_i;
      end else begin
        mode_d   = WALK_GEN;
        cur_x_d  = x0_i;
        cur_y_d  = y0_i;
        stop_x_d = x1_i;
        stop_y_d = y1_i;
      end
    end else if (take_step) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        unique case (mode_q)
          WALK_VERT:  cur_y_d = cur_y_q + COORD_BITS'(1);
          WALK_HORIZ: cur_x_d = cur_x_q + COORD_BITS'(1);
          default: begin
            err_d = err_q;
            if (e2 > neg_dy) begin
              err_d = err_d - ERR_W'(signed'({1'b0, dy_q}));
              case (dir_x_q)
                DIR_PLUS:  cur_x_d = cur_x_q + COORD_BITS'(1);
                DIR_MINUS: cur_x_d = cur_x_q - COORD_BITS'(1);
                default:   cur_x_d = cur_x_q;
              endcase
            end
            if (e2 < pos_dx) begin
              err_d = err_d + ERR_W'(signed'({1'b0, dx_q}));
              case (dir_y_q)
                DIR_PLUS:  cur_y_d = cur_y_q + COORD_BITS'(1);
                DIR_MINUS: cur_y_d = cur_y_q - COORD_BITS'(1);
                default:   cur_y_d = cur_y_q;
              endcase
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (take_step) begin
      s1_valid_d = 1'b1;
    end else if (adv_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      mode_q     <= WALK_VERT;
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      stop_x_q   <= '0;
      stop_y_q   <= '0;
      dx_q       <= '0;
      dy_q       <= '0;
      dir_x_q    <= DIR_NONE;
      dir_y_q    <= DIR_NONE;
      err_q      <= '0;
      color_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      mode_q     <= mode_d;
      cur_x_q    <= cur_x_d;
      cur_y_q    <= cur_y_d;
      stop_x_q   <= stop_x_d;
      stop_y_q   <= stop_y_d;
      dx_q       <= dx_d;
      dy_q       <= dy_d;
      dir_x_q    <= dir_x_d;
      dir_y_q    <= dir_y_d;
      err_q      <= err_d;
      color_q    <= color_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_step) begin
      s1_x_q     <= cur_x_q;
      s1_y_q     <= cur_y_q;
      s1_last_q  <= last;
      s1_color_q <= color_q;
    end
  end

  assign pix_valid_o = s1_valid_q;
  assign pix_x_o     = s1_x_q;
  assign pix_y_o     = s1_y_q;
  assign pix_last_o  = s1_last_q;
  assign pix_color_o = s1_color_q;

endmodule

FILE: design/lrc_emit.sv
// lrc_emit: clipping, byte offset and colour masking into the result register
// depends on lrc_pkg
module lrc_emit
  import lrc_pkg::*;
#(
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_t                         cfg_i,
  input  logic                         pix_valid_i,
  input  logic signed [COORD_BITS-1:0] pix_x_i,
  input  logic signed [COORD_BITS-1:0] pix_y_i,
  input  logic                         pix_last_i,
  input  logic [COLOR_W-1:0]           pix_color_i,
  output logic                         adv_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] out_x_o,
  output logic signed [COORD_BITS-1:0] out_y_o,
  output logic                         out_we_o,
  output logic [OFFSET_BITS-1:0]       out_offset_o,
  output logic [COLOR_W-1:0]           out_color_o,
  output logic                         out_last_o
);

  localparam int unsigned CMP_W  = (COORD_BITS > WIDTH_W) ? COORD_BITS : WIDTH_W;
  localparam int unsigned ROW_W  = COORD_BITS + PITCH_W;
  localparam int unsigned COL_W  = COORD_BITS + 2;
  localparam int unsigned SUM_W  = COORD_BITS + PITCH_W + 1;
  localparam int unsigned OFS_W  = (SUM_W > OFFSET_BITS) ? SUM_W : OFFSET_BITS;

  logic                   valid_q;
  logic [COORD_BITS-1:0]  xu, yu;
  logic                   on_screen, fmt_ok, we;
  logic [ROW_W-1:0]       row_ofs;
  logic [COL_W-1:0]       col_ofs;
  logic [OFS_W-1:0]       sum;
  logic [COLOR_W-1:0]     color;

  assign xu = COORD_BITS'(unsigned'(pix_x_i));
  assign yu = COORD_BITS'(unsigned'(pix_y_i));

  assign on_screen = !pix_x_i[COORD_BITS-1] && !pix_y_i[COORD_BITS-1]
                  && (CMP_W'(xu) < CMP_W'(cfg_i.width))
                  && (CMP_W'(yu) < CMP_W'(cfg_i.height));
  assign fmt_ok    = (cfg_i.fmt == FMT_WIDE) || (cfg_i.fmt == FMT_NARROW);
  assign we        = on_screen && fmt_ok;

  assign row_ofs = ROW_W'(yu) * ROW_W'(cfg_i.pitch);

  // wide format: x*4, narrow format: x*3
  always_comb begin
    case (cfg_i.fmt)
      FMT_WIDE:   col_ofs = COL_W'(xu) << (BPP_WIDE / 16);
      default:    col_ofs = COL_W'(xu) + (COL_W'(xu) << 1);
    endcase
  end

  assign sum = OFS_W'(row_ofs) + OFS_W'(col_ofs);

  always_comb begin
    color = pix_color_i;
    if (cfg_i.fmt == FMT_NARROW) begin
      color = {{(COLOR_W - BPP_NARROW){1'b0}}, pix_color_i[BPP_NARROW-1:0]};
    end
  end

  assign adv_o       = ~valid_q | out_ready_i;
  assign out_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= pix_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && pix_valid_i) begin
      out_x_o      <= pix_x_i;
      out_y_o      <= pix_y_i;
      out_we_o     <= we;
      out_offset_o <= we ? sum[OFFSET_BITS-1:0] : '0;
      out_color_o  <= color;
      out_last_o   <= pix_last_i;
    end
  end

endmodule

FILE: dv/tb_top.sv
// tb_top: self-checking testbench for line_rasterizer_clipped
// depends on lrc_pkg and the rasterizer rtl; predicts every pixel of the
// walk and checks it field by field against the master side
module tb_top
  import lrc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W  = 96;
  localparam int OUT_W = 96;

  // one predicted pixel as it should leave the master side
  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        we;
    logic [25:0] off;
    logic [31:0] color;
    logic        last;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             s_tvalid_i = 1'b0;
  logic             s_tready_o;
  // start_x, start_y, end_x, end_y, line_color from the lowest bit up
  logic [IN_W-1:0]  s_tdata_i = '0;
  // action
  logic [0:0]       s_tuser_i = ACT_START;
  logic             m_tvalid_o;
  logic             m_tready_i = 1'b0;
  // pixel_x, pixel_y, byte_offset, pixel_color from the lowest bit up
  logic [OUT_W-1:0] m_tdata_o;
  // write_enable
  logic [0:0]       m_tuser_o;
  logic             m_tlast_o;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // screen registers as the predictor sees them
  logic [WIDTH_W-1:0]  scr_w = WIDTH_RST;
  logic [HEIGHT_W-1:0] scr_h = HEIGHT_RST;
  logic [PITCH_W-1:0]  scr_pitch = PITCH_RST;
  pix_fmt_e            scr_fmt = FMT_WIDE;

  // walk state of the predictor
  logic       line_busy = 1'b0;
  walk_mode_e walk = WALK_VERT;
  int         cur_x, cur_y, stop_x, stop_y;
  int         span_x, span_y;
  dir_e       dir_x = DIR_NONE;
  dir_e       dir_y = DIR_NONE;
  int         err_term;
  logic [31:0] held_color = '0;

  pixel_t expected_pixels[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_in = 0;
  int pixels_seen = 0;
  int pixels_written = 0;
  int mismatches = 0;
  int settings_used = 0;
  int cfg_round = 0;

  line_rasterizer_clipped uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #4 clk_i = ~clk_i;

  // hard stop in case the pipeline hangs
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  // receiver backpressure, redrawn every cycle
  always @(negedge clk_i) begin
    m_tready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s expected 0x%0h got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // pixel checker: each master transfer against the oldest prediction
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      pixels_seen++;
      if (m_tuser_o[0]) pixels_written++;
      if (expected_pixels.size() == 0) begin
        $error("pixel transfer with no step waiting for it: x 0x%0h y 0x%0h",
               m_tdata_o[15:0], m_tdata_o[31:16]);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("pixel_x", want.x, m_tdata_o[15:0]);
        check_field("pixel_y", want.y, m_tdata_o[31:16]);
        check_field("byte_offset", want.off, m_tdata_o[57:32]);
        check_field("pixel_color", want.color, m_tdata_o[89:58]);
        check_field("write_enable", want.we, m_tuser_o[0]);
        check_field("last_pixel", want.last, m_tlast_o);
      end
    end
  end

  // predictor: advance the walk for one accepted transfer
  function automatic void predict_item(action_e act, logic [IN_W-1:0] data);
    int x0, y0, x1, y1, e2, bytes;
    logic [63:0] full_off;
    pixel_t px;
    x0 = int'($signed(data[15:0]));
    y0 = int'($signed(data[31:16]));
    x1 = int'($signed(data[47:32]));
    y1 = int'($signed(data[63:48]));
    if (act == ACT_START) begin
      // a start drops whatever line was in flight
      held_color = data[95:64];
      span_x = (x1 > x0) ? x1 - x0 : x0 - x1;
      span_y = (y1 > y0) ? y1 - y0 : y0 - y1;
      dir_x = (x1 > x0) ? DIR_PLUS : ((x1 < x0) ? DIR_MINUS : DIR_NONE);
      dir_y = (y1 > y0) ? DIR_PLUS : ((y1 < y0) ? DIR_MINUS : DIR_NONE);
      if (span_x == 0) begin
        // vertical, also the single point: top row down
        walk = WALK_VERT;
        cur_x = x0;
        stop_x = x0;
        cur_y = (y0 < y1) ? y0 : y1;
        stop_y = (y0 < y1) ? y1 : y0;
      end else if (span_y == 0) begin
        walk = WALK_HORIZ;
        cur_y = y0;
        stop_y = y0;
        cur_x = (x0 < x1) ? x0 : x1;
        stop_x = (x0 < x1) ? x1 : x0;
      end else begin
        walk = WALK_GEN;
        cur_x = x0;
        cur_y = y0;
        stop_x = x1;
        stop_y = y1;
      end
      err_term = span_x - span_y;
      line_busy = 1'b1;
      return;
    end
    // step with no line loaded is dropped
    if (!line_busy) return;

    bytes = (scr_fmt == FMT_WIDE) ? BPP_WIDE / 8 :
            (scr_fmt == FMT_NARROW) ? BPP_NARROW / 8 : 0;
    px.x = cur_x[15:0];
    px.y = cur_y[15:0];
    px.we = cur_x >= 0 && cur_y >= 0 && cur_x < int'(scr_w) && cur_y < int'(scr_h)
            && bytes != 0;
    full_off = longint'(cur_y) * longint'(scr_pitch) + longint'(cur_x * bytes);
    px.off = px.we ? full_off[25:0] : '0;
    px.color = (scr_fmt == FMT_NARROW) ? {8'h00, held_color[23:0]} : held_color;
    px.last = (cur_x == stop_x) && (cur_y == stop_y);
    expected_pixels.push_back(px);
    if (px.last) begin
      line_busy = 1'b0;
      return;
    end
    case (walk)
      WALK_VERT:  cur_y++;
      WALK_HORIZ: cur_x++;
      default: begin
        // bresenham error walk
        e2 = 2 * err_term;
        if (e2 > -span_y) begin
          err_term -= span_y;
          cur_x += (dir_x == DIR_PLUS) ? 1 : ((dir_x == DIR_MINUS) ? -1 : 0);
        end
        if (e2 < span_x) begin
          err_term += span_x;
          cur_y += (dir_y == DIR_PLUS) ? 1 : ((dir_y == DIR_MINUS) ? -1 : 0);
        end
      end
    endcase
  endfunction

  // one slave transfer, entered and left just after a falling edge
  task automatic send_item(action_e act, logic [IN_W-1:0] data);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i <= data;
    s_tuser_i <= act;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    // ignored steps are not counted as stimulus
    if (act == ACT_START || line_busy) items_in++;
    predict_item(act, data);
    @(negedge clk_i);
  endtask

  // start a line and step it until done or until the step budget runs out
  task automatic draw_line(int x0, int y0, int x1, int y1, logic [31:0] color,
                           int max_steps);
    send_item(ACT_START, {color, 16'(y1), 16'(x1), 16'(y0), 16'(x0)});
    for (int n = 0; n < max_steps && line_busy; n++) begin
      send_item(ACT_STEP, {$urandom, $urandom, $urandom});
    end
  endtask

  // drain every expected pixel, then cover the two stage pipeline
  task automatic wait_idle();
    s_tvalid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic reg_read(reg_idx_e idx, logic [APB_DATA_W-1:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    check_field("register readback", want, prdata);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // write one register, sometimes with junk above its width, then read it back
  task automatic reg_access(reg_idx_e idx, logic [APB_DATA_W-1:0] val);
    logic [APB_DATA_W-1:0] keep_mask, wdata;
    case (idx)
      REG_WIDTH:  keep_mask = (1 << WIDTH_W) - 1;
      REG_HEIGHT: keep_mask = (1 << HEIGHT_W) - 1;
      REG_PITCH:  keep_mask = (1 << PITCH_W) - 1;
      default:    keep_mask = (1 << FMT_W) - 1;
    endcase
    wdata = val & keep_mask;
    if ($urandom_range(3) == 0) wdata |= $urandom & ~keep_mask;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    case (idx)
      REG_WIDTH:  scr_w = wdata[WIDTH_W-1:0];
      REG_HEIGHT: scr_h = wdata[HEIGHT_W-1:0];
      REG_PITCH:  scr_pitch = wdata[PITCH_W-1:0];
      default:    scr_fmt = pix_fmt_e'(wdata[FMT_W-1:0]);
    endcase
    reg_read(idx, wdata & keep_mask);
  endtask

  // new screen setup, only with no line and no pixel in flight
  task automatic apply_screen(int w, int h, int pitch, pix_fmt_e fmt);
    if (line_busy) draw_line(0, 0, 0, 0, $urandom, 1);
    wait_idle();
    reg_access(REG_WIDTH, w);
    reg_access(REG_HEIGHT, h);
    reg_access(REG_PITCH, pitch);
    reg_access(REG_FORMAT, fmt);
    settings_used++;
  endtask

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // mostly near the top left, some across the screen, some anywhere, some at the 16-bit range ends
  function automatic int pick_coord(int lim);
    int r;
    r = $urandom_range(99);
    if (lim > 32000) lim = 32000;
    if (r < 50) return $urandom_range(44) - 4;
    if (r < 80) return $urandom_range(lim + 8) - 4;
    if (r < 92) return int'($signed(16'($urandom)));
    return $urandom_range(1) ? 32767 - $urandom_range(3) : -32768 + $urandom_range(3);
  endfunction

  task automatic random_line();
    int x0, y0, x1, y1, span, shape, max_steps;
    logic far;
    x0 = pick_coord(int'(scr_w));
    y0 = pick_coord(int'(scr_h));
    span = ($urandom_range(99) < 82) ? 12 : 80;
    far = ($urandom_range(99) < 5);
    if (far) begin
      x1 = int'($signed(16'($urandom)));
      y1 = int'($signed(16'($urandom)));
    end else begin
      x1 = clamp16(x0 + $urandom_range(2 * span) - span);
      y1 = clamp16(y0 + $urandom_range(2 * span) - span);
    end
    // bias toward the straight walks and the single point
    shape = $urandom_range(99);
    if (shape < 8) x1 = x0;
    else if (shape < 16) y1 = y0;
    else if (shape < 19) begin
      x1 = x0;
      y1 = y0;
    end
    if (far) max_steps = $urandom_range(40);
    else if ($urandom_range(99) < 85) max_steps = 2 * span + 2;
    else max_steps = $urandom_range(span);
    draw_line(x0, y0, x1, y1, $urandom, max_steps);
    // occasional steps after the final pixel fall on an idle walk
    if (!line_busy && $urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 2)) send_item(ACT_STEP, {$urandom, $urandom, $urandom});
    end
  endtask

  task automatic test_reset_values();
    reg_read(REG_WIDTH, WIDTH_RST);
    reg_read(REG_HEIGHT, HEIGHT_RST);
    reg_read(REG_PITCH, PITCH_RST);
    reg_read(REG_FORMAT, FMT_WIDE);
  endtask

  // every walk kind on the default 640x480 screen
  task automatic test_walk_shapes();
    send_item(ACT_STEP, '1);                        // step with no line: dropped
    draw_line(5, 7, 5, 7, 32'h00a1b2c3, 4);         // single point
    draw_line(3, 4, 3, 2, 32'h11223344, 8);         // vertical, walked downward
    draw_line(9, 1, 7, 1, 32'h55667788, 8);         // horizontal, walked rightward
    draw_line(0, 0, 3, -1, 32'h99aabbcc, 8);        // shallow, partly above screen
    draw_line(2, 5, 1, 8, 32'hddeeff00, 8);         // steep, leftward
    draw_line(100, 100, 110, 105, 32'h0f0f0f0f, 2); // cut short by the next start
    draw_line(639, 479, 640, 480, 32'hf0f0f0f0, 4); // right/bottom clip edge
    send_item(ACT_STEP, '0);                        // step after the end: dropped
  endtask

  // coordinate and colour extremes, off screen everywhere
  task automatic test_coord_extremes();
    draw_line(32767, -32768, 32765, -32766, 32'hffffffff, 8);
    draw_line(-32768, 32767, -32768, 32765, 32'h00000000, 1);
    draw_line(32765, 32767, 32767, 32767, 32'h5a5a5a5a, 8);
    draw_line(-32768, -32768, 32767, 32767, 32'ha5a5a5a5, 3);
  endtask

  // random lines over a rotation of fixed and random screen setups
  task automatic test_random_lines(int target, int chunks);
    int base;
    for (int c = 0; c < chunks; c++) begin
      case (cfg_round % 6)
        0: apply_screen(640, 480, 2560, FMT_WIDE);
        1: apply_screen(1, 1, 1, FMT_NARROW);
        2: apply_screen(4096, 4096, 16384, FMT_WIDE);
        // above the nominal range: offsets wrap to 26 bits
        3: apply_screen(8191, 8191, 32767, FMT_NARROW);
        // zero width keeps every pixel off screen
        4: apply_screen(0, $urandom_range(1, 4096), 0, FMT_WIDE);
        default: apply_screen($urandom_range(1, 4096), $urandom_range(1, 4096),
                              $urandom_range(1, 16384), pix_fmt_e'($urandom_range(3)));
      endcase
      cfg_round++;
      base = items_in;
      while (items_in - base < target / chunks) random_line();
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // sender mostly busy, receiver mostly stalled
    tx_idle_pct = 6;
    rx_idle_pct = 73;
    test_reset_values();
    test_walk_shapes();
    test_coord_extremes();
    test_random_lines(580, 5);

    // sender mostly idle, receiver mostly ready
    tx_idle_pct = 73;
    rx_idle_pct = 6;
    test_random_lines(580, 5);

    // full rate both ways
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_lines(590, 5);

    wait_idle();
    repeat (8) @(negedge clk_i);

    $display("run covered %0d accepted transfers and %0d pixels (%0d written)",
             items_in, pixels_seen, pixels_written);
    $display("across %0d screen setups, %0d mismatches", settings_used, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: line_rasterizer_clipped.f
design/lrc_pkg.sv
design/lrc_walk.sv
design/lrc_emit.sv
design/line_rasterizer_clipped.sv
dv/tb_top.sv
